// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types for the four-class stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_PER_CLASS = 16;
    localparam int CLASS_COUNT     = 4;
    localparam int TAG_W           = 16;

    localparam int PTR_W   = (DEPTH_PER_CLASS > 1) ? $clog2(DEPTH_PER_CLASS) : 1;
    localparam int CLS_W   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int CNT_W   = $clog2(DEPTH_PER_CLASS + 1);
    localparam int ADDR_W  = CLS_W + PTR_W;
    localparam int STORE_N = 1 << ADDR_W;

    localparam int FUNC_W   = 1;
    localparam int PRIO_W   = 2;
    localparam int STATUS_W = 2;
    localparam int ROOM_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED    = 2'd0,
        ST_POPPED    = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [ROOM_W-1:0] {
        ROOM_EMERGENCY    = 2'd0,
        ROOM_EXAMINATION  = 2'd1,
        ROOM_CONSULTATION = 2'd2
    } t_room;

    localparam logic [CLS_W-1:0] CLS_CRITICAL = CLS_W'(0);
    localparam logic [CLS_W-1:0] CLS_SERIOUS  = CLS_W'(1);

    function automatic t_room room_of(input logic [CLS_W-1:0] cls);
        t_room r;
        if (cls == CLS_CRITICAL) begin
            r = ROOM_EMERGENCY;
        end else if (cls == CLS_SERIOUS) begin
            r = ROOM_EXAMINATION;
        end else begin
            r = ROOM_CONSULTATION;
        end
        return r;
    endfunction

endpackage

// File: hdl/stable_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Four-class queue, first-in order within a class, tags held in one
// synchronous ram with per-class ring pointers and counts in flops.
//
//  channel   signals                                   direction
//  command   start, busy, i_func, i_priority_req, i_tag  in (busy out)
//  result    strobe, o_status, o_out_tag,              out
//            o_out_priority, o_room
//
// one transfer per cycle; the result strobes in the cycle after its command,
// the cycle taken by the tag ram read.
// a push written at one edge is visible to a pop accepted the next cycle,
// so busy stays low and no interlock is needed.
// reset clears pointers, counts and the strobe; the ram needs no clearing.
// the receiver cannot stall: every result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module stable_priority_queue_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spq_pkg::FUNC_W-1:0]    i_func,
    input  logic [spq_pkg::PRIO_W-1:0]    i_priority_req,
    input  logic [spq_pkg::TAG_W-1:0]     i_tag,
    output logic                          strobe,
    output logic [spq_pkg::STATUS_W-1:0]  o_status,
    output logic [spq_pkg::TAG_W-1:0]     o_out_tag,
    output logic [spq_pkg::PRIO_W-1:0]    o_out_priority,
    output logic [spq_pkg::ROOM_W-1:0]    o_room
);
    import spq_pkg::*;

    logic [TAG_W-1:0] r_store [STORE_N];

    logic [PTR_W-1:0] r_rd_ptr [CLASS_COUNT];
    logic [PTR_W-1:0] r_wr_ptr [CLASS_COUNT];
    logic [CNT_W-1:0] r_cnt    [CLASS_COUNT];
    logic [PTR_W-1:0] n_rd_ptr [CLASS_COUNT];
    logic [PTR_W-1:0] n_wr_ptr [CLASS_COUNT];
    logic [CNT_W-1:0] n_cnt    [CLASS_COUNT];

    logic             r_strobe;
    t_status          r_status;
    logic             r_popped;
    logic [CLS_W-1:0] r_cls;
    logic [TAG_W-1:0] r_rd_data;

    logic             accept;
    logic             is_pop;
    logic             cls_ok;
    logic [CLS_W-1:0] push_cls;
    logic             push_ok;
    logic             any_full;
    logic             found;
    logic [CLS_W-1:0] pop_cls;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    t_status          n_status;

    assign accept   = start && !busy;
    assign is_pop   = (t_func'(i_func) == FUNC_POP);
    assign cls_ok   = (32'(i_priority_req) < 32'(CLASS_COUNT));
    assign push_cls = CLS_W'(i_priority_req);

    // most urgent non-empty class
    always_comb begin
        found   = 1'b0;
        pop_cls = '0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if (r_cnt[c] != '0) begin
                found   = 1'b1;
                pop_cls = CLS_W'(c);
            end
        end
    end

    always_comb begin
        any_full = 1'b1;
        if (cls_ok) begin
            any_full = (32'(r_cnt[push_cls]) >= 32'(DEPTH_PER_CLASS));
        end
    end

    assign push_ok = !is_pop && !any_full;
    assign wr_en   = accept && push_ok;
    assign wr_addr = {push_cls, r_wr_ptr[push_cls]};
    assign rd_addr = {pop_cls, r_rd_ptr[pop_cls]};

    always_comb begin
        for (int c = 0; c < CLASS_COUNT; c++) begin
            n_rd_ptr[c] = r_rd_ptr[c];
            n_wr_ptr[c] = r_wr_ptr[c];
            n_cnt[c]    = r_cnt[c];
        end
        n_status = ST_PUSHED;
        if (is_pop) begin
            n_status = found ? ST_POPPED : ST_EMPTY;
        end else if (!push_ok) begin
            n_status = ST_FULL;
        end
        if (accept) begin
            if (is_pop && found) begin
                n_rd_ptr[pop_cls] = (32'(r_rd_ptr[pop_cls]) == DEPTH_PER_CLASS - 1)
                                    ? '0 : r_rd_ptr[pop_cls] + PTR_W'(1);
                n_cnt[pop_cls]    = r_cnt[pop_cls] - CNT_W'(1);
            end else if (push_ok) begin
                n_wr_ptr[push_cls] = (32'(r_wr_ptr[push_cls]) == DEPTH_PER_CLASS - 1)
                                     ? '0 : r_wr_ptr[push_cls] + PTR_W'(1);
                n_cnt[push_cls]    = r_cnt[push_cls] + CNT_W'(1);
            end
        end
    end

    // tag ram
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= i_tag;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_rd_ptr[c] <= '0;
                r_wr_ptr[c] <= '0;
                r_cnt[c]    <= '0;
            end
            r_strobe <= 1'b0;
        end else begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_rd_ptr[c] <= n_rd_ptr[c];
                r_wr_ptr[c] <= n_wr_ptr[c];
                r_cnt[c]    <= n_cnt[c];
            end
            r_strobe <= accept;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_popped <= is_pop && found;
            r_cls    <= pop_cls;
        end
    end

    assign busy           = 1'b0;
    assign strobe         = r_strobe;
    assign o_status       = r_status;
    assign o_out_tag      = r_popped ? r_rd_data : '0;
    assign o_out_priority = r_popped ? PRIO_W'(r_cls) : '0;
    assign o_room         = r_popped ? room_of(r_cls) : ROOM_EMERGENCY;

endmodule

// File: verif/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches the command and result channels of the four-class priority queue,
// keeps its own copy of the per-class rings to predict the result of every
// accepted command, and compares each strobed result with the oldest
// prediction still waiting. Failures and progress counts go to the top.
// ----------------------------------------------------------------------------
module spq_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [spq_pkg::FUNC_W-1:0]    i_func,
    input  logic [spq_pkg::PRIO_W-1:0]    i_priority_req,
    input  logic [spq_pkg::TAG_W-1:0]     i_tag,
    input  logic                          strobe,
    input  logic [spq_pkg::STATUS_W-1:0]  o_status,
    input  logic [spq_pkg::TAG_W-1:0]     o_out_tag,
    input  logic [spq_pkg::PRIO_W-1:0]    o_out_priority,
    input  logic [spq_pkg::ROOM_W-1:0]    o_room,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_stored,
    output int                            o_served,
    output int                            o_empty_pops,
    output int                            o_full_pushes
);

    typedef struct packed {
        spq_pkg::t_status              status;
        logic [spq_pkg::TAG_W-1:0]     tag;
        logic [spq_pkg::PRIO_W-1:0]    cls;
        spq_pkg::t_room                room;
    } t_reply;

    logic [spq_pkg::TAG_W-1:0] ring_tags [spq_pkg::CLASS_COUNT][spq_pkg::DEPTH_PER_CLASS];
    int     head_ptr [spq_pkg::CLASS_COUNT];
    int     tail_ptr [spq_pkg::CLASS_COUNT];
    int     fill     [spq_pkg::CLASS_COUNT];
    t_reply awaited_replies [$];

    int fail_count   = 0;
    int pending      = 0;
    int stored       = 0;
    int served       = 0;
    int empty_pops   = 0;
    int full_pushes  = 0;

    assign o_fail_count  = fail_count;
    assign o_pending     = pending;
    assign o_stored      = stored;
    assign o_served      = served;
    assign o_empty_pops  = empty_pops;
    assign o_full_pushes = full_pushes;

    function automatic int ring_step(input int p);
        return (p == spq_pkg::DEPTH_PER_CLASS - 1) ? 0 : p + 1;
    endfunction

    function automatic spq_pkg::t_room room_for(input int c);
        spq_pkg::t_room r;
        case (c)
            0:       r = spq_pkg::ROOM_EMERGENCY;
            1:       r = spq_pkg::ROOM_EXAMINATION;
            default: r = spq_pkg::ROOM_CONSULTATION;
        endcase
        return r;
    endfunction

    function automatic t_reply serve_command(input spq_pkg::t_func f,
                                             input logic [spq_pkg::PRIO_W-1:0] cls_req,
                                             input logic [spq_pkg::TAG_W-1:0] tag);
        t_reply r;
        int     c;
        bit     found;
        r = '{status: spq_pkg::ST_PUSHED, tag: '0, cls: '0, room: spq_pkg::ROOM_EMERGENCY};
        found = 1'b0;
        if (f == spq_pkg::FUNC_PUSH) begin
            c = int'(cls_req);
            if (c >= spq_pkg::CLASS_COUNT || fill[c] >= spq_pkg::DEPTH_PER_CLASS) begin
                r.status = spq_pkg::ST_FULL;
                full_pushes++;
            end else begin
                ring_tags[c][tail_ptr[c]] = tag;
                tail_ptr[c] = ring_step(tail_ptr[c]);
                fill[c]++;
                stored++;
            end
        end else begin
            for (c = 0; c < spq_pkg::CLASS_COUNT && !found; c++) begin
                if (fill[c] != 0) begin
                    found    = 1'b1;
                    r.status = spq_pkg::ST_POPPED;
                    r.tag    = ring_tags[c][head_ptr[c]];
                    r.cls    = c[spq_pkg::PRIO_W-1:0];
                    r.room   = room_for(c);
                    head_ptr[c] = ring_step(head_ptr[c]);
                    fill[c]--;
                    served++;
                end
            end
            if (!found) begin
                r.status = spq_pkg::ST_EMPTY;
                empty_pops++;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            for (int c = 0; c < spq_pkg::CLASS_COUNT; c++) begin
                head_ptr[c] = 0;
                tail_ptr[c] = 0;
                fill[c]     = 0;
            end
            awaited_replies.delete();
        end else begin
            if (strobe) begin
                if (awaited_replies.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (o_status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_out_tag !== want.tag) begin
                        $error("out_tag expected %h got %h", want.tag, o_out_tag);
                        fail_count++;
                    end
                    if (o_out_priority !== want.cls) begin
                        $error("out_priority expected %0d got %0d", want.cls, o_out_priority);
                        fail_count++;
                    end
                    if (o_room !== want.room) begin
                        $error("room expected %0d got %0d", want.room, o_room);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                awaited_replies.push_back(serve_command(spq_pkg::t_func'(i_func),
                                                        i_priority_req, i_tag));
            end
        end
        pending = awaited_replies.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the four-class priority queue: a directed opening on empty
// pops, extreme tags and in-class order, then random push and pop mixes
// that fill, drain, balance or hammer single classes, some blocks with random idle gaps.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BLOCK_COUNT = 15;
    localparam int BLOCK_ITEMS = 100;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_HAMMER} t_mix;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [spq_pkg::FUNC_W-1:0]    i_func;
    logic [spq_pkg::PRIO_W-1:0]    i_priority_req;
    logic [spq_pkg::TAG_W-1:0]     i_tag;
    logic                          strobe;
    logic [spq_pkg::STATUS_W-1:0]  o_status;
    logic [spq_pkg::TAG_W-1:0]     o_out_tag;
    logic [spq_pkg::PRIO_W-1:0]    o_out_priority;
    logic [spq_pkg::ROOM_W-1:0]    o_room;

    int fail_count;
    int pending;
    int stored;
    int served;
    int empty_pops;
    int full_pushes;
    int cycle_count = 0;
    int sent = 0;

    stable_priority_queue_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_priority_req (i_priority_req),
        .i_tag          (i_tag),
        .strobe         (strobe),
        .o_status       (o_status),
        .o_out_tag      (o_out_tag),
        .o_out_priority (o_out_priority),
        .o_room         (o_room)
    );

    spq_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_priority_req (i_priority_req),
        .i_tag          (i_tag),
        .strobe         (strobe),
        .o_status       (o_status),
        .o_out_tag      (o_out_tag),
        .o_out_priority (o_out_priority),
        .o_room         (o_room),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_stored       (stored),
        .o_served       (served),
        .o_empty_pops   (empty_pops),
        .o_full_pushes  (full_pushes)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic issue(input spq_pkg::t_func f, input int cls, input int tag);
        @(negedge i_clk);
        start          <= 1'b1;
        i_func         <= f;
        i_priority_req <= cls[spq_pkg::PRIO_W-1:0];
        i_tag          <= tag[spq_pkg::TAG_W-1:0];
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        sent++;
    endtask

    task automatic rest(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // hold commands back until every result is in
    task automatic drain();
        rest(1);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_mix          mix;
        int            focus;
        int            push_pct;
        int            cls;
        bit            gappy;
        spq_pkg::t_func f;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_func         = spq_pkg::FUNC_PUSH;
        i_priority_req = '0;
        i_tag          = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty pop, extreme tags in every class, order within a class
        issue(spq_pkg::FUNC_POP, 3, 16'hffff);
        issue(spq_pkg::FUNC_PUSH, 3, 16'h0000);
        issue(spq_pkg::FUNC_PUSH, 2, 16'hffff);
        issue(spq_pkg::FUNC_PUSH, 1, 16'h5555);
        issue(spq_pkg::FUNC_PUSH, 0, 16'haaaa);
        issue(spq_pkg::FUNC_PUSH, 3, 16'h8001);
        issue(spq_pkg::FUNC_PUSH, 0, 16'h7ffe);
        issue(spq_pkg::FUNC_POP, 0, 16'h0000);
        issue(spq_pkg::FUNC_POP, 2, 16'h1234);
        issue(spq_pkg::FUNC_PUSH, 0, 16'h0001);
        repeat (6) issue(spq_pkg::FUNC_POP, 1, 16'hffff);
        issue(spq_pkg::FUNC_POP, 0, 16'h0000);
        issue(spq_pkg::FUNC_POP, 3, 16'h0000);
        drain();

        for (int blk = 0; blk < BLOCK_COUNT; blk++) begin
            mix   = t_mix'(blk % 4);
            focus = $urandom_range(0, 3);
            gappy = (blk < BLOCK_COUNT - 2) && ($urandom_range(0, 2) != 0);
            case (mix)
                MIX_FILL:   push_pct = 85;
                MIX_DRAIN:  push_pct = 20;
                MIX_EVEN:   push_pct = 50;
                MIX_HAMMER: push_pct = 75;
                default:    push_pct = 50;
            endcase
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                if (gappy && $urandom_range(0, 5) == 0) rest($urandom_range(1, 17));
                f   = ($urandom_range(0, 99) < push_pct) ? spq_pkg::FUNC_PUSH
                                                         : spq_pkg::FUNC_POP;
                cls = (mix == MIX_HAMMER && $urandom_range(0, 3) != 0)
                      ? focus : $urandom_range(0, 3);
                issue(f, cls, $urandom);
            end
            if (blk == BLOCK_COUNT / 2) drain();
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("%0d commands: %0d pushes stored, %0d refused on a full class",
                 sent, stored, full_pushes);
        $display("%0d pops served in class order, %0d pops on an empty queue",
                 served, empty_pops);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
